// File: sv/vln_pkg.sv
`timescale 1ns / 1ps
package vln_pkg;
	// fixed field widths
	localparam int ELEM_W = 16;
	localparam int MAG_W  = 17;
	localparam int SQ_W   = 31;
	localparam int SUM_W  = 36;
	localparam int ROOT_W = 18;
	localparam int NORM_W = 24;
	localparam int NUM_W  = 32;
	localparam int FRAC_SH = 14;
	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
	localparam logic [NUM_W-1:0] UNIT_ONE  = 32'd16384;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [MAG_W-1:0] mag_t;

	// magnitude of a signed component
	function automatic mag_t mag_of(input elem_t e);
		mag_t x;
		x = {e[ELEM_W-1], e};
		return e[ELEM_W-1] ? (MAG_W'(0) - x) : x;
	endfunction
endpackage

// File: sv/vln_ram.sv
`timescale 1ns / 1ps
module vln_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// File: sv/vln_sqrt.sv
`timescale 1ns / 1ps
module vln_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [vln_pkg::SUM_W-1:0] radicand,
	output logic done,
	output logic [vln_pkg::ROOT_W-1:0] root
);
	import vln_pkg::*;

	localparam int REM_W = 21;

	logic [SUM_W-1:0] val_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [REM_W-1:0] rem_sh, trial;
	logic fits;

	// one root bit per cycle: bring down two radicand bits, try (root<<2)|1
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], val_q[SUM_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root = root_q;
endmodule

// File: sv/vln_div.sv
`timescale 1ns / 1ps
module vln_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [vln_pkg::NUM_W-1:0] numer,
	input  logic [vln_pkg::ROOT_W-1:0] denom,
	output logic done,
	output logic [vln_pkg::NUM_W-1:0] quot
);
	import vln_pkg::*;

	logic [NUM_W-1:0] nq_q;
	logic [ROOT_W-1:0] rem_q, den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [ROOT_W:0] rem_sh;
	logic fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, nq_q[NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ROOT_W'(rem_sh - {1'b0, den_q}) : rem_sh[ROOT_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign quot = nq_q;
endmodule

// File: sv/vector_l2_normalize_unit.sv
`timescale 1ns / 1ps
// channel | handshake            | fields
// in      | in_valid, in_ready   | element, last
// out     | out_valid, out_ready | unit_element, norm_value, zero_norm, overflow, last_out
// Loading: each component is squared on acceptance, then accumulated; in_ready is low in between.
// After last: the square root runs (18 root bits, one a cycle) before the first read.
// Each result: read, start, 32-step bit-serial divide, hand-off, output; a zero vector skips
// the divide; each result then waits in ST_OUT for out_ready.
// Input is held off while results drain.
// Reset clears the run state; the component buffer needs no clearing.
module vector_l2_normalize_unit #(
	parameter int MAX_LENGTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] element,
	input  logic last,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] unit_element,
	output logic [23:0] norm_value,
	output logic zero_norm,
	output logic overflow,
	output logic last_out
);
	import vln_pkg::*;

	localparam int AW = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;
	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LENGTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_DIVW = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;
	localparam logic [2:0] ST_SQW  = 3'd7;

	logic [2:0] state_q;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0] cnt_q, k_q;
	logic ovf_q, last_s1, stored_s1, sign_q;
	logic [SQ_W-1:0] sq_s1;
	logic [ROOT_W-1:0] norm_q;
	logic zero_q;
	logic accept;
	logic [ELEM_W-1:0] rdata;
	logic sqrt_done, div_done, div_start, sqrt_start;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0] quot, numer, qsat;
	logic [SUM_W:0] sum_add;
	mag_t rmag, imag;

	assign in_ready   = state_q == ST_IDLE;
	assign accept     = in_valid && in_ready;
	assign sqrt_start = state_q == ST_SQRT;
	assign div_start  = state_q == ST_DIVS && !zero_q;

	// component buffer
	vln_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LENGTH)) u_ram (
		.clk(clk),
		.we(accept && cnt_q < MAX_CNT),
		.waddr(cnt_q[AW-1:0]),
		.wdata(element),
		.re(state_q == ST_RD),
		.raddr(k_q[AW-1:0]),
		.rdata(rdata)
	);

	vln_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(sum_q), .done(sqrt_done), .root(root)
	);

	vln_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.numer(numer), .denom(norm_q), .done(div_done), .quot(quot)
	);

	// numerator: |e| * 2^14 + norm/2 for round to nearest
	always_comb begin
		imag    = mag_of(element);
		rmag    = mag_of(rdata);
		numer   = {1'b0, rmag, {FRAC_SH{1'b0}}} + {{(NUM_W-ROOT_W+1){1'b0}}, norm_q[ROOT_W-1:1]};
		qsat    = quot > UNIT_ONE ? UNIT_ONE : quot;
		sum_add = {1'b0, sum_q} + {{(SUM_W+1-SQ_W){1'b0}}, sq_s1};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cnt_q >= MAX_CNT) ovf_q <= 1'b1;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (stored_s1) begin
						sum_q <= sum_add > {1'b0, SUM_LIMIT} ? SUM_LIMIT : sum_add[SUM_W-1:0];
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= last_s1 ? ST_SQRT : ST_IDLE;
				end
				ST_SQRT: state_q <= ST_SQW;
				ST_SQW: begin
					if (sqrt_done) begin
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_DIVS;
				ST_DIVS: begin
					if (zero_q) begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (k_q + CW'(1) == cnt_q) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1     <= SQ_W'(imag) * SQ_W'(imag);
			stored_s1 <= cnt_q < MAX_CNT;
			last_s1   <= last;
		end
		if (state_q == ST_SQRT) zero_q <= sum_q == '0;
		if (sqrt_done) norm_q <= root;
		if (state_q == ST_DIVS) begin
			sign_q <= rdata[ELEM_W-1];
			if (zero_q) unit_element <= '0;
			norm_value <= {{(NORM_W-ROOT_W){1'b0}}, norm_q};
			zero_norm  <= zero_q;
			overflow   <= ovf_q;
			last_out   <= k_q + CW'(1) == cnt_q;
		end
		if (state_q == ST_DIVW && div_done)
			unit_element <= sign_q ? 16'sd0 - $signed(qsat[15:0]) : $signed(qsat[15:0]);
	end
endmodule

// File: sv/vln_checker.sv
`timescale 1ns / 1ps
module vln_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] unit_element,
	input logic [23:0] norm_value,
	input logic zero_norm
);
	// a zero vector gives zero results
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> unit_element == 16'sd0 && norm_value == 24'd0)
		else $error("zero norm with nonzero result");

	// unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_element <= 16'sd16384 && unit_element >= -16'sd16384)
		else $error("unit element out of range");

	// no loading while results drain
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unit_element))
		else $error("stalled result changed");
endmodule

bind vector_l2_normalize_unit vln_checker u_vln_checker (.*);

// File: tb/vector_l2_normalize_unit_tb.sv
`timescale 1ns / 1ps
module vector_l2_normalize_unit_tb;
	import vln_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic signed [15:0] element;
		logic               last;
	} comp_t;

	typedef struct packed {
		logic signed [15:0] unit_element;
		logic [23:0]        norm_value;
		logic               zero_norm;
		logic               overflow;
		logic               last_out;
	} unit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] element = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] unit_element;
	logic [23:0] norm_value;
	logic zero_norm;
	logic overflow;
	logic last_out;

	comp_t pending_q[$];
	unit_t unit_q[$];
	int errors = 0;
	int vectors_done = 0;
	int units_seen = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	// predictor state
	logic signed [15:0] buf_mem[DEPTH];
	logic [35:0] sum_sq = '0;
	int n_held = 0;
	bit dropped = 0;

	always #6 clk = ~clk;

	vector_l2_normalize_unit #(.MAX_LENGTH(DEPTH)) u_top (.*);

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// absorb one component; on last, queue the normalized vector
	task automatic predict_unit_vector(input comp_t c);
		logic [63:0] sq, s, nrm, mag, q;
		logic signed [31:0] e;
		unit_t r;
		bit zero;
		if (n_held < DEPTH) begin
			e = c.element;
			sq = 64'(e * e);
			buf_mem[n_held] = c.element;
			n_held++;
			s = 64'(sum_sq) + sq;
			if (s > 64'(SUM_LIMIT)) s = 64'(SUM_LIMIT);
			sum_sq = s[35:0];
		end else begin
			dropped = 1;
		end
		if (!c.last) return;
		zero = (sum_sq == 0);
		nrm = zero ? 0 : int_sqrt(64'(sum_sq));
		for (int k = 0; k < n_held; k++) begin
			e = buf_mem[k];
			if (zero) begin
				r.unit_element = '0;
			end else begin
				mag = 64'(e < 0 ? -e : e) * 64'd16384;
				q = (mag + nrm / 2) / nrm;
				if (q > 64'd16384) q = 64'd16384;
				r.unit_element = e < 0 ? -16'(q) : 16'(q);
			end
			r.norm_value = nrm[23:0];
			r.zero_norm = zero;
			r.overflow = dropped;
			r.last_out = (k + 1 == n_held);
			unit_q.push_back(r);
		end
		sum_sq = '0;
		n_held = 0;
		dropped = 0;
		vectors_done++;
	endtask

	task automatic push_vec(input int len, input int kind);
		comp_t c;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: c.element = 16'($urandom);
				1: c.element = 16'($urandom_range(0, 15)) - 16'sd8;
				2: c.element = '0;
				3: c.element = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
				default: c.element = 16'($urandom_range(0, 2047)) - 16'sd1024;
			endcase
			c.last = (i == len - 1);
			pending_q.push_back(c);
		end
	endtask

	// stimulus
	initial begin
		comp_t c;
		// directed: extremes, zero vector, single, overflow
		c = '{16'sh7fff, 1'b1}; pending_q.push_back(c);
		c = '{16'sh8000, 1'b1}; pending_q.push_back(c);
		c = '{16'sh0000, 1'b1}; pending_q.push_back(c);
		c = '{16'sh0001, 1'b0}; pending_q.push_back(c);
		c = '{16'shffff, 1'b1}; pending_q.push_back(c);
		push_vec(3, 2);
		push_vec(DEPTH, 3);
		push_vec(DEPTH + 2, 4);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() < 230) begin
			case ($urandom_range(0, 9))
				0: push_vec($urandom_range(DEPTH + 1, DEPTH + 4), $urandom_range(0, 4));
				1: push_vec($urandom_range(1, 3), 2);
				2: push_vec($urandom_range(1, 4), 1);
				3: push_vec(DEPTH, 3);
				default: push_vec($urandom_range(1, 8), $urandom_range(0, 4));
			endcase
		end
		stim_done = 1;
	end

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_unit_vector('{element, last});
				void'(pending_q.pop_front());
				in_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0) in_gap = 0;
			end
			if (in_gap > 0 && !(in_valid && !in_ready)) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (!(in_valid && !in_ready)) begin
				if (pending_q.size() > 0) begin
					in_valid <= 1'b1;
					element <= pending_q[0].element;
					last <= pending_q[0].last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once, mid-run
	initial begin
		wait (vectors_done == 20);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		unit_t got, exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{unit_element, norm_value, zero_norm, overflow, last_out};
				units_seen++;
				if (unit_q.size() == 0) begin
					$display("%0t unexpected result %p", $time, got);
					errors++;
				end else begin
					exp_r = unit_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t mismatch expected %p actual %p", $time, exp_r, got);
						errors++;
					end
				end
				out_gap = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0) out_gap = 0;
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (pending_q.size() == 0 && !in_valid);
		wait (unit_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d vectors, %0d normalized components", vectors_done, units_seen);
		if (errors == 0 && unit_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// File: files.f
sv/vln_pkg.sv
sv/vln_ram.sv
sv/vln_sqrt.sv
sv/vln_div.sv
sv/vector_l2_normalize_unit.sv
sv/vln_checker.sv
tb/vector_l2_normalize_unit_tb.sv
